// ===== sv/rrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_pkg
// Types and codes shared by the run queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int OP_BITS   = 3;
  localparam int KIND_BITS = 3;

  // Thread ids are eight bits wide on both channels.
  localparam int THREAD_ID_BITS = 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_ENQ     = 3'd0,
    OP_DEQ     = 3'd1,
    OP_FETCH   = 3'd2,
    OP_TICK    = 3'd3,
    OP_STEAL   = 3'd4
  } op_t;

  typedef enum logic [KIND_BITS-1:0] {
    RK_DONE    = 3'd0,
    RK_HANDOUT = 3'd1,
    RK_REAP    = 3'd2,
    RK_RESCHED = 3'd3,
    RK_FULL    = 3'd4
  } rkind_t;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_DYING = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REAP,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic reap_step;
    logic resched;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic zombie_left;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/round_robin_run_queue_with_steal_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_run_queue_with_steal_top
// Hardware run queue with fetch, dequeue, tick reaping and work stealing.
// ----------------------------------------------------------------------------
// Each word is executed in S_EXEC, then its result waits in the output
// register; a new word is taken once the last result of the previous word is
// taken, so no new word enters while results are pending. A tick with N
// zombies gives N+1 results, the first from S_EXEC and the rest from S_REAP;
// the queue cells are compared in parallel and shifted on removal.
module round_robin_run_queue_with_steal_top #(
  parameter int RUN_QUEUE_DEPTH = 16,
  parameter int ZOMBIE_DEPTH    = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // opcode[2:0], thread_id[10:3], thread_state[12:11], is_idle[13], is_init[14],
  // affinity_cpu[17:15], affinity_kind[18], current_thread[26:19],
  // stealer_cpu[29:27], zero fill to 32
  input  wire  [31:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // result_kind[2:0], out_thread[10:3], found[11], run_count[16:12], zero fill
  output logic [23:0] m_tdata,
  output logic        m_tlast
);
  import rrq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [2:0] rk;
  logic [THREAD_ID_BITS-1:0] ot;
  logic       fnd;
  logic [4:0] rc;

  rrq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready)
      , .stat(stat), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
  );

  rrq_dp #(.RQ_DEPTH(RUN_QUEUE_DEPTH), .Z_DEPTH(ZOMBIE_DEPTH), .TID_BITS(THREAD_ID_BITS))
  u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .opcode(s_tdata[2:0]), .thread_id(s_tdata[10:3]), .thread_state(s_tdata[12:11]),
    .is_idle(s_tdata[13]), .is_init(s_tdata[14]), .affinity_cpu(s_tdata[17:15]),
    .affinity_kind(s_tdata[18]), .current_thread(s_tdata[26:19]),
    .steal_cpu(s_tdata[29:27]), .stat(stat),
    .result_kind(rk), .out_thread(ot), .found(fnd), .run_count(rc), .last(m_tlast)
  );

  assign m_tdata = {7'd0, rc, fnd, ot, rk};

endmodule
`default_nettype wire

// ===== sv/rrq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_ctrl
// Sequencer: takes a word, runs it in the datapath, drives reap results, and
// holds the result stage until the consumer takes it.
// ----------------------------------------------------------------------------
module rrq_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_fire,
  input  wire              out_fire,
  input  wire rrq_pkg::stat_t stat,
  output rrq_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import rrq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_REAP: state_next = S_OUT;
      S_OUT: begin
        if (out_fire) begin
          if (stat.is_tick && stat.zombie_left) state_next = S_REAP;
          else if (stat.is_tick) state_next = S_REAP;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_fire;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_REAP: cmd.reap_step = 1'b1;
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rrq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrq_dp
// Run queue cells, zombie FIFO and the result register.
// ----------------------------------------------------------------------------
module rrq_dp #(
  parameter int RQ_DEPTH = 16,
  parameter int Z_DEPTH  = 16,
  parameter int TID_BITS = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire rrq_pkg::cmd_t          cmd,
  input  wire  [2:0]                  opcode,
  input  wire  [TID_BITS-1:0]         thread_id,
  input  wire  [1:0]                  thread_state,
  input  wire                         is_idle,
  input  wire                         is_init,
  input  wire  [2:0]                  affinity_cpu,
  input  wire                         affinity_kind,
  input  wire  [TID_BITS-1:0]         current_thread,
  input  wire  [2:0]                  steal_cpu,
  output rrq_pkg::stat_t              stat,
  output logic [2:0]                  result_kind,
  output logic [TID_BITS-1:0]         out_thread,
  output logic                        found,
  output logic [4:0]                  run_count,
  output logic                        last
);
  import rrq_pkg::*;

  localparam int RQ_IB = $clog2(RQ_DEPTH);
  localparam int RQ_CB = $clog2(RQ_DEPTH + 1);
  localparam int Z_IB  = (Z_DEPTH > 1) ? $clog2(Z_DEPTH) : 1;
  localparam int Z_CB  = $clog2(Z_DEPTH + 1);

  typedef struct packed {
    logic [TID_BITS-1:0] id;
    logic                ready;
    logic                idle;
    logic                init;
    logic [2:0]          cpu;
    logic                kind;
  } ent_t;

  ent_t                ent [RQ_DEPTH];
  logic [RQ_CB-1:0]    cnt;
  logic [TID_BITS-1:0] zf [Z_DEPTH];
  logic [Z_CB-1:0]     zcnt;
  logic [Z_CB-1:0]     zptr;

  // Captured item.
  logic [2:0]          op_r;
  logic [TID_BITS-1:0] tid_r, cur_r;
  logic [1:0]          st_r;
  logic                idle_r, init_r, akind_r;
  logic [2:0]          acpu_r, scpu_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= opcode; tid_r <= thread_id; st_r <= thread_state;
      idle_r <= is_idle; init_r <= is_init; acpu_r <= affinity_cpu;
      akind_r <= affinity_kind; cur_r <= current_thread; scpu_r <= steal_cpu;
    end
  end

  // Parallel match over the cells, then priority select.
  logic [RQ_DEPTH-1:0] m_deq, m_p0, m_p1, m_p2;
  always_comb begin
    for (int i = 0; i < RQ_DEPTH; i++) begin
      logic v, el;
      v  = (RQ_CB'(i) < cnt);
      el = v && ent[i].id != cur_r && ent[i].ready && !ent[i].idle && !ent[i].init;
      m_deq[i] = v && ent[i].id == tid_r;
      m_p0[i]  = el && ent[i].cpu == scpu_r;
      m_p1[i]  = el && !ent[i].kind;
      m_p2[i]  = el && ent[i].kind;
    end
  end

  logic [RQ_IB-1:0] deq_i, st_i;
  logic             deq_hit, st_hit;
  always_comb begin
    deq_i = '0; deq_hit = 1'b0;
    for (int i = RQ_DEPTH - 1; i >= 0; i--)
      if (m_deq[i]) begin deq_i = RQ_IB'(i); deq_hit = 1'b1; end
    st_i = '0; st_hit = 1'b1;
    if (|m_p0) begin
      for (int i = 0; i < RQ_DEPTH; i++) if (m_p0[i]) st_i = RQ_IB'(i);
    end else if (|m_p1) begin
      for (int i = 0; i < RQ_DEPTH; i++) if (m_p1[i]) st_i = RQ_IB'(i);
    end else if (|m_p2) begin
      for (int i = 0; i < RQ_DEPTH; i++) if (m_p2[i]) st_i = RQ_IB'(i);
    end else st_hit = 1'b0;
  end

  logic             rm;
  logic [RQ_IB-1:0] rm_i;
  logic             push, zpush;
  always_comb begin
    rm = 1'b0; rm_i = '0; push = 1'b0; zpush = 1'b0;
    if (cmd.exec) begin
      case (op_r)
        OP_ENQ: begin
          if (st_r == ST_DYING) zpush = (zcnt < Z_CB'(Z_DEPTH));
          else push = (cnt < RQ_CB'(RQ_DEPTH));
        end
        OP_DEQ: begin rm = deq_hit; rm_i = deq_i; end
        OP_FETCH: rm = (cnt != '0);
        OP_STEAL: begin rm = st_hit; rm_i = st_i; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[cnt[RQ_IB-1:0]] <= '{tid_r, st_r == ST_READY, idle_r, init_r, acpu_r,
                                      akind_r};
    if (rm)
      for (int i = 0; i < RQ_DEPTH - 1; i++)
        if (RQ_IB'(i) >= rm_i) ent[i] <= ent[i+1];
    if (zpush) zf[zcnt[Z_IB-1:0]] <= tid_r;
  end

  logic [4:0] cnt_after;
  always_comb begin
    cnt_after = 5'(cnt);
    if (push) cnt_after = 5'(cnt + 1'b1);
    else if (rm) cnt_after = 5'(cnt - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; zcnt <= '0; zptr <= '0;
    end else begin
      if (push) cnt <= cnt + 1'b1;
      else if (rm) cnt <= cnt - 1'b1;
      if (zpush) zcnt <= zcnt + 1'b1;
      if (cmd.exec) zptr <= '0;
      if (cmd.reap_step && zptr != zcnt) zptr <= zptr + 1'b1;
      // The FIFO empties once the reschedule word is built.
      if (cmd.reap_step && !(zptr + 1'b1 < zcnt)) zcnt <= '0;
    end
  end

  // Result register. A tick starts by reaping; its first word is built in exec, the rest in reap.
  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.reap_step) begin
      result_kind <= RK_DONE; out_thread <= '0; found <= 1'b0; last <= 1'b1;
      run_count <= cnt_after;
    end
    if (cmd.exec) begin
      case (op_r)
        OP_ENQ: if ((st_r == ST_DYING) ? !zpush : !push) begin
          result_kind <= RK_FULL; out_thread <= tid_r;
        end
        OP_FETCH: if (rm) begin
          result_kind <= RK_HANDOUT; out_thread <= ent[0].id; found <= 1'b1;
        end
        OP_STEAL: if (rm) begin
          result_kind <= RK_HANDOUT; out_thread <= ent[st_i].id; found <= 1'b1;
        end
        OP_TICK: begin
          if (zcnt != '0) begin
            result_kind <= RK_REAP; out_thread <= zf[0]; last <= 1'b0;
          end else begin
            result_kind <= RK_RESCHED; out_thread <= cur_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd.reap_step) begin
      if (zptr + 1'b1 < zcnt) begin
        result_kind <= RK_REAP; out_thread <= zf[Z_IB'(zptr + 1'b1)]; last <= 1'b0;
      end else begin
        result_kind <= RK_RESCHED; out_thread <= cur_r;
      end
    end
  end

  assign stat.is_tick     = (op_r == OP_TICK) && !last;
  assign stat.zombie_left = (zptr != zcnt);

endmodule
`default_nettype wire
